// File: src/tbsu_pkg.sv
// Package for the TOML basic string unescape block.
// Holds the result status codes, the queue entry type and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package tbsu_pkg;

    // Default depth of the queue between the front and back parts.
    localparam int TBSU_QDEPTH = 4;

    // Highest code point that may be emitted.
    localparam logic [20:0] TBSU_CP_MAX = 21'h10FFFF;

    // Status codes carried with every result beat.
    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_CLOSED   = 3'd1,
        ST_NEWLINE  = 3'd2,
        ST_BADESC   = 3'd3,
        ST_BADUNI   = 3'd4,
        ST_UNCLOSED = 3'd5
    } t_status;

    // What the back part has to do with one queue entry.
    typedef enum logic [1:0] {
        JOB_BYTE   = 2'd0,
        JOB_STATUS = 2'd1,
        JOB_CP     = 2'd2
    } t_job_op;

    // One queue entry: a plain byte, a status, or a code point to encode.
    typedef struct packed {
        t_job_op     op;
        t_status     status;
        logic [20:0] data;
    } t_job;

    // Fill flags of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

// File: src/tbsu_in_if.sv
// Input channel of the TOML basic string unescape block.
// Carries one string byte or an end of input marker per beat. No dependencies.
`timescale 1ns / 1ps

interface tbsu_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

// File: src/tbsu_out_if.sv
// Output channel of the TOML basic string unescape block.
// Carries one decoded byte or status per beat. No dependencies.
`timescale 1ns / 1ps

interface tbsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       run_last;

    modport source (output valid, output out_byte, output status, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input run_last,
                    output ready);
endinterface

// File: src/tbsu_front.sv
// Front part: accepts input beats, tracks escape state and collects hex digits.
// Pushes one job per item that causes results. Depends on tbsu_pkg, tbsu_in_if.
`timescale 1ns / 1ps

module tbsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbsu_in_if.sink       i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output tbsu_pkg::t_job o_job
);
    import tbsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [4:0] HEX_BAD = 5'd16;

    logic        r_esc;
    logic [3:0]  r_hex_left;
    logic [31:0] r_acc;
    logic        n_esc;
    logic [3:0]  n_hex_left;
    logic [31:0] n_acc;

    logic        accept;
    logic [4:0]  digit;
    logic [31:0] acc_shift;
    logic [3:0]  left_dec;
    logic        cp_reject;

    // Digit value of a hex character, or HEX_BAD if it is not one.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        case (c) inside
            [8'h30:8'h39]: return {1'b0, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: return {1'b0, c[3:0] + 4'd9};
            default:       return HEX_BAD;
        endcase
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    // Next accumulator value and the checks on the finished code point.
    assign digit     = hex_value(i_in.in_byte);
    assign acc_shift = {r_acc[27:0], digit[3:0]};
    assign left_dec  = r_hex_left - 4'd1;
    assign cp_reject = (|acc_shift[31:21]) || (acc_shift[20:0] > TBSU_CP_MAX) ||
                       ((acc_shift[20:7] == '0) &&
                        (((acc_shift[6:0] <= 7'h1F) && (acc_shift[6:0] != 7'h09)) ||
                         (acc_shift[6:0] == 7'h7F)));

    // Classification of the accepted beat.
    always_comb begin
        n_esc      = r_esc;
        n_hex_left = r_hex_left;
        n_acc      = r_acc;
        o_push     = 1'b0;
        o_job      = '{op: JOB_STATUS, status: ST_UNCLOSED, data: '0};
        if (accept) begin
            if (i_in.kind) begin
                o_push     = 1'b1;
                o_job      = '{op: JOB_STATUS,
                               status: (r_hex_left != '0) ? ST_BADUNI : ST_UNCLOSED,
                               data: '0};
                n_esc      = 1'b0;
                n_hex_left = '0;
                n_acc      = '0;
            end else if (r_hex_left != '0) begin
                if (digit == HEX_BAD) begin
                    o_push     = 1'b1;
                    o_job      = '{op: JOB_STATUS, status: ST_BADUNI, data: '0};
                    n_esc      = 1'b0;
                    n_hex_left = '0;
                    n_acc      = '0;
                end else if (left_dec != '0) begin
                    n_acc      = acc_shift;
                    n_hex_left = left_dec;
                end else begin
                    o_push     = 1'b1;
                    if (cp_reject) begin
                        o_job = '{op: JOB_STATUS, status: ST_BADUNI, data: '0};
                    end else begin
                        o_job = '{op: JOB_CP, status: ST_BYTE, data: acc_shift[20:0]};
                    end
                    n_esc      = 1'b0;
                    n_hex_left = '0;
                    n_acc      = '0;
                end
            end else if (r_esc) begin
                n_esc  = 1'b0;
                o_push = 1'b1;
                case (i_in.in_byte)
                    8'h6E:     o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h0A};
                    8'h72:     o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h0D};
                    8'h74:     o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h09};
                    8'h62:     o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h08};
                    8'h66:     o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h0C};
                    CH_BSLASH: o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h5C};
                    CH_QUOTE:  o_job = '{op: JOB_BYTE, status: ST_BYTE, data: 21'h22};
                    8'h75: begin
                        o_push     = 1'b0;
                        n_hex_left = 4'd4;
                        n_acc      = '0;
                    end
                    8'h55: begin
                        o_push     = 1'b0;
                        n_hex_left = 4'd8;
                        n_acc      = '0;
                    end
                    default: begin
                        o_job      = '{op: JOB_STATUS, status: ST_BADESC, data: '0};
                        n_hex_left = '0;
                        n_acc      = '0;
                    end
                endcase
            end else begin
                o_push = 1'b1;
                case (i_in.in_byte)
                    CH_QUOTE: begin
                        o_job = '{op: JOB_STATUS, status: ST_CLOSED, data: '0};
                        n_acc = '0;
                    end
                    CH_BSLASH: begin
                        o_push = 1'b0;
                        n_esc  = 1'b1;
                    end
                    CH_LF, CH_CR: begin
                        o_job = '{op: JOB_STATUS, status: ST_NEWLINE, data: '0};
                        n_acc = '0;
                    end
                    default: begin
                        o_job = '{op: JOB_BYTE, status: ST_BYTE,
                                  data: {13'd0, i_in.in_byte}};
                    end
                endcase
            end
        end
    end

    // Escape and hex collection state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= 1'b0;
            r_hex_left <= '0;
            r_acc      <= '0;
        end else begin
            r_esc      <= n_esc;
            r_hex_left <= n_hex_left;
            r_acc      <= n_acc;
        end
    end

endmodule

// File: src/tbsu_fifo.sv
// Short queue of jobs between the front and back parts.
// Register array with read and write pointers. Depends on tbsu_pkg.
`timescale 1ns / 1ps

module tbsu_fifo #(
    parameter int DEPTH = tbsu_pkg::TBSU_QDEPTH   // two or more entries
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tbsu_pkg::t_job     i_job,
    input  logic               i_pop,
    output tbsu_pkg::t_job     o_head,
    output tbsu_pkg::t_q_flags o_flags
);
    import tbsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_flags.full  = (r_cnt == CW'(DEPTH));
    assign o_flags.empty = (r_cnt == '0);
    assign push_ok       = i_push && !o_flags.full;
    assign pop_ok        = i_pop && !o_flags.empty;
    assign o_head        = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/tbsu_back.sv
// Back part: turns queued jobs into result beats, one byte per beat.
// Encodes code points as UTF-8. Depends on tbsu_pkg, tbsu_out_if.
`timescale 1ns / 1ps

module tbsu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbsu_pkg::t_job     i_job,
    input  tbsu_pkg::t_q_flags i_flags,
    output logic               o_pop,
    tbsu_out_if.source         o_out
);
    import tbsu_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    t_status    r_status;
    logic       r_last;
    logic [1:0] r_idx;

    logic       slot_free;
    logic       load;
    logic [1:0] last_idx;
    logic [7:0] cur_byte;

    // Index of the final UTF-8 byte for a code point.
    function automatic logic [1:0] cp_last(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            return 2'd0;
        end else if (cp <= 21'h7FF) begin
            return 2'd1;
        end else if (cp <= 21'hFFFF) begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

    // One byte of the UTF-8 form, given the final index and the byte index.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                             input logic [1:0] k);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        case (last)
            2'd0: b = cp[7:0];
            2'd1: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2: begin
                case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (k)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

    // Shape of the job at the head of the queue.
    always_comb begin
        case (i_job.op)
            JOB_CP: begin
                last_idx = cp_last(i_job.data);
                cur_byte = utf8_byte(i_job.data, last_idx, r_idx);
            end
            JOB_BYTE: begin
                last_idx = 2'd0;
                cur_byte = i_job.data[7:0];
            end
            default: begin
                last_idx = 2'd0;
                cur_byte = 8'd0;
            end
        endcase
    end

    assign slot_free = !r_valid || o_out.ready;
    assign load      = slot_free && !i_flags.empty;
    assign o_pop     = load && (r_idx == last_idx);

    // Output register control and byte index within the current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (slot_free) begin
            r_valid <= !i_flags.empty;
            if (load) begin
                r_idx <= (r_idx == last_idx) ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Output beat payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= cur_byte;
            r_status <= i_job.status;
            r_last   <= (r_idx == last_idx);
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.status   = r_status;
    assign o_out.run_last = r_last;

endmodule

// File: src/toml_basic_string_unescape_top.sv
// An accepted input beat's job is queued at the accepting edge, then moves into the
// output register once that register is free. Input beats are taken one per cycle
// while the queue is not full; output beats leave one per cycle while the sink is
// ready, from a single output register, so a four-byte code point occupies it for
// four beats. The job queue (QDEPTH entries) absorbs that burst while input continues.
// Reset is synchronous and active low; it clears the escape state, the queue
// pointers and the output valid. The block accepts input in the first cycle after.
`timescale 1ns / 1ps

module toml_basic_string_unescape_top #(
    parameter int QDEPTH = tbsu_pkg::TBSU_QDEPTH   // two or more entries
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbsu_in_if.sink    i_in,
    tbsu_out_if.source o_out
);
    import tbsu_pkg::*;

    logic     push;
    t_job     push_job;
    logic     pop;
    t_job     head_job;
    t_q_flags q_flags;

    // Classification of input beats.
    tbsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_flags.full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Job queue.
    tbsu_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_flags (q_flags)
    );

    // Result generation.
    tbsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_flags (q_flags),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: src/tbsu_checker.sv
// Port-level checks for the TOML basic string unescape block.
// Bound to toml_basic_string_unescape_top. Depends on tbsu_pkg.
`timescale 1ns / 1ps

module tbsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [2:0] i_out_status,
    input logic       i_out_run_last
);
    import tbsu_pkg::*;

    // No output beat is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled output beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_status) &&
             $stable(i_out_run_last)))
        else $error("stalled output beat changed");

    // A status beat always closes its run and carries a zero byte.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status != ST_BYTE)) |->
            (i_out_run_last && (i_out_byte == 8'd0) && (i_out_status <= ST_UNCLOSED)))
        else $error("malformed status beat");

    // Only multi-byte UTF-8 sequences have beats before the last; those bytes
    // are lead or continuation bytes.
    a_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_run_last) |->
            ((i_out_status == ST_BYTE) && i_out_byte[7]))
        else $error("non-final beat is not a UTF-8 multi-byte part");

endmodule

bind toml_basic_string_unescape_top tbsu_checker u_tbsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_status   (o_out.status),
    .i_out_run_last (o_out.run_last)
);

// File: sim/tbsu_tb_pkg.sv
// Character and input kind constants shared by the unescape testbench files.
// Depends on nothing; used by the checker and the testbench top.
`timescale 1ns / 1ps

package tbsu_tb_pkg;

    // Input beat kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Raw characters with a meaning of their own in a string body, and escape results.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Escape letters that follow a backslash.
    localparam logic [7:0] ESC_NEWLINE   = "n";
    localparam logic [7:0] ESC_RETURN    = "r";
    localparam logic [7:0] ESC_TAB       = "t";
    localparam logic [7:0] ESC_BACKSPACE = "b";
    localparam logic [7:0] ESC_FORMFEED  = "f";
    localparam logic [7:0] ESC_UNI4      = "u";
    localparam logic [7:0] ESC_UNI8      = "U";

    // Every escape that maps to a single byte.
    localparam logic [7:0] SIMPLE_ESCAPES [7] = '{ESC_NEWLINE, ESC_RETURN, ESC_TAB,
                                                  ESC_BACKSPACE, ESC_FORMFEED,
                                                  CH_BSLASH, CH_QUOTE};

endpackage

// File: sim/tbsu_decode_checker.sv
// Checker for the TOML basic string unescape block: watches both channels,
// decodes each accepted input beat itself and compares the result beats.
// Depends on tbsu_pkg, tbsu_tb_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module tbsu_decode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tbsu_in_if   i_in_mon,
    tbsu_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_backlog
);
    import tbsu_pkg::*;
    import tbsu_tb_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       run_last;
    } t_decoded_beat;

    // Result beats still owed by the block, oldest first.
    t_decoded_beat decoded_due[$];

    // Decoder state as the block should hold it.
    logic        in_escape      = 1'b0;
    logic [3:0]  hex_digits_due = 4'd0;
    logic [31:0] code_point_acc = 32'd0;
    int          fail_count     = 0;

    task automatic push_byte(input logic [7:0] value, input logic last);
        t_decoded_beat beat;
        beat.out_byte = value;
        beat.status   = ST_BYTE;
        beat.run_last = last;
        decoded_due.insert(decoded_due.size(), beat);
    endtask

    // A status beat closes the string and the decoder starts afresh.
    task automatic end_string(input t_status st);
        t_decoded_beat beat;
        in_escape      = 1'b0;
        hex_digits_due = 4'd0;
        code_point_acc = 32'd0;
        beat.out_byte  = 8'd0;
        beat.status    = st;
        beat.run_last  = 1'b1;
        decoded_due.insert(decoded_due.size(), beat);
    endtask

    task automatic decode_string_byte(input logic kind, input logic [7:0] c);
        logic [7:0]  utf8 [4];
        logic [4:0]  digit;
        logic [31:0] cp;
        int          n;
        if (kind == KIND_END) begin
            end_string(hex_digits_due != 4'd0 ? ST_BADUNI : ST_UNCLOSED);
        end else if (hex_digits_due != 4'd0) begin
            // Each hex digit is checked as it arrives.
            digit = 5'd16;
            if (c >= "0" && c <= "9") begin
                digit = {1'b0, c[3:0]};
            end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
                digit = {1'b0, c[3:0]} + 5'd9;
            end
            if (digit == 5'd16) begin
                end_string(ST_BADUNI);
            end else begin
                code_point_acc = {code_point_acc[27:0], digit[3:0]};
                hex_digits_due = hex_digits_due - 4'd1;
                cp = code_point_acc;
                if (hex_digits_due == 4'd0) begin
                    // Controls other than tab, delete and anything past the
                    // Unicode range are refused; surrogates pass.
                    if (cp <= 32'h08 || (cp >= 32'h0A && cp <= 32'h1F) || cp == 32'h7F ||
                        cp > {11'd0, TBSU_CP_MAX}) begin
                        end_string(ST_BADUNI);
                    end else begin
                        if (cp <= 32'h7F) begin
                            utf8[0] = cp[7:0];
                            n = 1;
                        end else if (cp <= 32'h7FF) begin
                            utf8[0] = 8'hC0 | {3'd0, cp[10:6]};
                            utf8[1] = 8'h80 | {2'd0, cp[5:0]};
                            n = 2;
                        end else if (cp <= 32'hFFFF) begin
                            utf8[0] = 8'hE0 | {4'd0, cp[15:12]};
                            utf8[1] = 8'h80 | {2'd0, cp[11:6]};
                            utf8[2] = 8'h80 | {2'd0, cp[5:0]};
                            n = 3;
                        end else begin
                            utf8[0] = 8'hF0 | {5'd0, cp[20:18]};
                            utf8[1] = 8'h80 | {2'd0, cp[17:12]};
                            utf8[2] = 8'h80 | {2'd0, cp[11:6]};
                            utf8[3] = 8'h80 | {2'd0, cp[5:0]};
                            n = 4;
                        end
                        for (int k = 0; k < n; k++) begin
                            push_byte(utf8[k], k == n - 1);
                        end
                        code_point_acc = 32'd0;
                    end
                end
            end
        end else if (in_escape) begin
            in_escape = 1'b0;
            case (c)
                ESC_NEWLINE:   push_byte(CH_LF, 1'b1);
                ESC_RETURN:    push_byte(CH_CR, 1'b1);
                ESC_TAB:       push_byte(CH_TAB, 1'b1);
                ESC_BACKSPACE: push_byte(CH_BS, 1'b1);
                ESC_FORMFEED:  push_byte(CH_FF, 1'b1);
                CH_BSLASH:     push_byte(CH_BSLASH, 1'b1);
                CH_QUOTE:      push_byte(CH_QUOTE, 1'b1);
                ESC_UNI4: begin
                    hex_digits_due = 4'd4;
                    code_point_acc = 32'd0;
                end
                ESC_UNI8: begin
                    hex_digits_due = 4'd8;
                    code_point_acc = 32'd0;
                end
                default:       end_string(ST_BADESC);
            endcase
        end else if (c == CH_QUOTE) begin
            end_string(ST_CLOSED);
        end else if (c == CH_BSLASH) begin
            in_escape = 1'b1;
        end else if (c == CH_LF || c == CH_CR) begin
            end_string(ST_NEWLINE);
        end else begin
            push_byte(c, 1'b1);
        end
    endtask

    // Results are compared before the input of the same edge is decoded; a
    // result never comes from an input beat accepted at the same edge.
    always @(posedge i_clk) begin
        t_decoded_beat want;
        if (!i_rst_n) begin
            decoded_due.delete();
            in_escape      = 1'b0;
            hex_digits_due = 4'd0;
            code_point_acc = 32'd0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (decoded_due.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected result beat, byte %02h status %0d last %0b",
                             $time, i_out_mon.out_byte, i_out_mon.status,
                             i_out_mon.run_last);
                end else begin
                    want = decoded_due.pop_front();
                    if (i_out_mon.out_byte !== want.out_byte ||
                        i_out_mon.status !== want.status ||
                        i_out_mon.run_last !== want.run_last) begin
                        fail_count++;
                        $display("%0t ns: mismatch, byte/status/last expected %02h/%0d/%0b %s",
                                 $time, want.out_byte, want.status, want.run_last,
                                 $sformatf("got %02h/%0d/%0b", i_out_mon.out_byte,
                                           i_out_mon.status, i_out_mon.run_last));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_string_byte(i_in_mon.kind, i_in_mon.in_byte);
            end
        end
        o_backlog    <= decoded_due.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: sim/toml_basic_string_unescape_top_tb.sv
// Testbench top for the TOML basic string unescape block: drives string bodies
// with random gaps and stalls, and gives the verdict from the checker's count.
// Depends on tbsu_pkg, tbsu_tb_pkg, the channel interfaces and the checker.
`timescale 1ns / 1ps

module toml_basic_string_unescape_top_tb;
    import tbsu_pkg::*;
    import tbsu_tb_pkg::*;

    localparam int STIM_ITEMS     = 410;
    localparam int GAP_MAX        = 17;
    localparam int HOLD_CYCLES    = 80;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tbsu_in_if  in_ch ();
    tbsu_out_if out_ch ();

    int fail_count;
    int backlog;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    toml_basic_string_unescape_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tbsu_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_backlog    (backlog)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one input beat after a random gap and returns once it is taken.
    // Valid stays high on return so that back-to-back beats need no toggle.
    task automatic send_beat(input logic kind, input logic [7:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.kind    = kind;
        in_ch.in_byte = value;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Sends a u or U escape with the first ndigits hex digits of cp, in mixed case.
    task automatic send_hex_escape(input bit wide, input logic [31:0] cp, input int ndigits);
        logic [3:0] nib;
        logic [7:0] ch;
        int         total;
        total = wide ? 8 : 4;
        send_beat(KIND_BYTE, CH_BSLASH);
        send_beat(KIND_BYTE, wide ? ESC_UNI8 : ESC_UNI4);
        for (int i = 0; i < ndigits; i++) begin
            nib = cp[4 * (total - 1 - i) +: 4];
            if (nib < 4'd10) begin
                ch = "0" + 8'(nib);
            end else begin
                ch = ($urandom_range(0, 1) ? "A" : "a") + 8'(nib) - 8'd10;
            end
            send_beat(KIND_BYTE, ch);
        end
    endtask

    // One string body: a run of plain bytes and escapes, then a way to end it.
    task automatic send_random_string();
        logic [7:0]  b;
        logic [31:0] cp;
        bit          wide;
        int          segs;
        int          pick;
        segs = $urandom_range(0, 8);
        repeat (segs) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF || b == CH_CR);
                send_beat(KIND_BYTE, b);
            end else if (pick < 7) begin
                send_beat(KIND_BYTE, CH_BSLASH);
                send_beat(KIND_BYTE, SIMPLE_ESCAPES[$urandom_range(0, 6)]);
            end else begin
                wide = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       cp = $urandom_range(32'h20, 32'h7E);
                    1:       cp = 32'(CH_TAB);
                    2:       cp = $urandom_range(0, 32'h1F);
                    3:       cp = 32'h7F;
                    4:       cp = $urandom_range(32'h80, 32'h7FF);
                    5:       cp = $urandom_range(32'h800, 32'hFFFF);
                    6:       cp = $urandom_range(32'hD800, 32'hDFFF);
                    7:       cp = $urandom_range(32'h10000, 32'h10FFFF);
                    8:       cp = $urandom_range(0, 1) ? 32'h10FFFF : 32'h110000;
                    default: cp = $urandom();
                endcase
                send_hex_escape(wide, cp, wide ? 8 : 4);
            end
        end

        wide = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
            11: send_beat(KIND_BYTE, CH_LF);
            12: send_beat(KIND_BYTE, CH_CR);
            13: begin
                // Unknown escape letter.
                send_beat(KIND_BYTE, CH_BSLASH);
                do b = 8'($urandom_range(0, 255));
                while (b inside {ESC_NEWLINE, ESC_RETURN, ESC_TAB, ESC_BACKSPACE,
                                 ESC_FORMFEED, CH_BSLASH, CH_QUOTE, ESC_UNI4, ESC_UNI8});
                send_beat(KIND_BYTE, b);
            end
            14: begin
                // A non-hex byte part way through the digits.
                send_hex_escape(wide, $urandom(), $urandom_range(0, wide ? 7 : 3));
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       b = CH_QUOTE;
                        1:       b = CH_BSLASH;
                        default: b = CH_LF;
                    endcase
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                           (b >= "a" && b <= "f"));
                end
                send_beat(KIND_BYTE, b);
            end
            15: begin
                // Input runs out while digits are still owed.
                send_hex_escape(wide, $urandom(), $urandom_range(0, wide ? 7 : 3));
                send_beat(KIND_END, 8'($urandom_range(0, 255)));
            end
            16: begin
                send_beat(KIND_BYTE, CH_BSLASH);
                send_beat(KIND_END, 8'($urandom_range(0, 255)));
            end
            17: send_beat(KIND_END, 8'($urandom_range(0, 255)));
            18, 19: begin
                send_beat(KIND_BYTE, 8'($urandom_range(0, 255)));
                send_beat(KIND_BYTE, CH_QUOTE);
            end
            default: send_beat(KIND_BYTE, CH_QUOTE);
        endcase
    endtask

    // Result side: a random stall before each beat, or a long hold on request.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Stimulus and verdict.
    initial begin
        bit held;
        bit paused;
        held          = 1'b0;
        paused        = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_BYTE;
        in_ch.in_byte = 8'd0;
        out_ch.ready  = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: byte extremes, every single-byte escape, each way to end.
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_BYTE, 8'hFF);
        foreach (SIMPLE_ESCAPES[i]) begin
            send_beat(KIND_BYTE, CH_BSLASH);
            send_beat(KIND_BYTE, SIMPLE_ESCAPES[i]);
        end
        send_beat(KIND_BYTE, CH_QUOTE);
        send_beat(KIND_BYTE, CH_LF);
        send_beat(KIND_BYTE, CH_CR);
        send_beat(KIND_BYTE, CH_BSLASH);
        send_beat(KIND_BYTE, "q");
        send_hex_escape(1'b0, 32'h7F, 4);
        send_hex_escape(1'b0, 32'h0, 0);
        send_beat(KIND_BYTE, CH_QUOTE);
        send_hex_escape(1'b1, 32'h0, 0);
        send_beat(KIND_END, 8'hFF);
        send_beat(KIND_END, 8'h00);

        // Random string bodies, with one long result hold and one full drain.
        while (items_sent < STIM_ITEMS) begin
            if (!held && items_sent >= 150) begin
                held     = 1'b1;
                quiet    = 1'b1;
                hold_req = 1'b1;
                repeat (6) send_hex_escape(1'b1, $urandom_range(32'h10000, 32'h10FFFF), 8);
                send_beat(KIND_BYTE, CH_QUOTE);
            end else if (!paused && items_sent >= 300) begin
                paused = 1'b1;
                // The last beat is withdrawn so that it is not taken again
                // while the results drain.
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                wait (backlog == 0);
            end
            quiet = ($urandom_range(0, 5) == 0);
            send_random_string();
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        wait (backlog == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && backlog == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
src/tbsu_pkg.sv
src/tbsu_in_if.sv
src/tbsu_out_if.sv
src/tbsu_front.sv
src/tbsu_fifo.sv
src/tbsu_back.sv
src/toml_basic_string_unescape_top.sv
src/tbsu_checker.sv
sim/tbsu_tb_pkg.sv
sim/tbsu_decode_checker.sv
sim/toml_basic_string_unescape_top_tb.sv
